FILE: design/assert_macros.svh
// Assertion macros used by the rasterizer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: design/polr_pkg.sv
// Shared types and constants of the polygon outline rasterizer
`default_nettype none
package polr_pkg;
    localparam int GRID_WORDS = 65536;
    localparam int GRID_AW = $clog2(GRID_WORDS);
    localparam int DDA_FRAC_BITS = 16;
    // pixel coordinates: Q16.8 * Q8.8 >> 16 keeps at most 25 bits
    localparam int PIX_W = 25;
    localparam int ACC_W = PIX_W + DDA_FRAC_BITS + 1;
    localparam int QUO_W = DDA_FRAC_BITS + 1;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_VERTEX = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [1:0] REG_COLS  = 2'd0;
    localparam logic [1:0] REG_ROWS  = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;
    localparam logic [1:0] REG_MARK  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load_in;      // latch the accepted item
        logic scale_a;      // scale the segment start
        logic scale_b;      // scale the segment end
        logic seg_setup;    // compute deltas and directions
        logic div_start;    // start the increment divisions
        logic div_step;     // one restoring-division step
        logic dda_init;     // load the accumulators
        logic plot;         // plot one pixel and advance
        logic sel_close;    // segment end is the first vertex
        logic commit;       // update vertex history
        logic clr_start;    // begin clearing sweep
        logic clr_step;     // write one clear entry
        logic rd_issue;     // issue the grid read
        logic rd_take;      // latch the read data
        logic load_out;     // present the result
    } polr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       have_first;
        logic       is_last;
        logic       need_close;
        logic       seg_zero;
        logic       div_done;
        logic       plot_done;
        logic       clr_done;
    } polr_stat_t;
endpackage
`default_nettype wire

FILE: design/polr_ram.sv
// Generic single-port RAM with registered read
`default_nettype none
module polr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one access per cycle, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: design/polr_datapath.sv
// Datapath: vertex history, scaling, division, DDA and grid access
`default_nettype none
module polr_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire polr_pkg::polr_cmd_t   ctl,
    output polr_pkg::polr_stat_t       st,
    input  wire logic [1:0]            in_cmd,
    input  wire logic [23:0]           in_x,
    input  wire logic [23:0]           in_y,
    input  wire logic                  in_last,
    input  wire logic [15:0]           in_addr,
    input  wire logic [15:0]           cols,
    input  wire logic [15:0]           rows,
    input  wire logic [15:0]           scale,
    input  wire logic [7:0]            mark,
    output logic [7:0]                 res_data,
    output logic [1:0]                 res_status
);
    import polr_pkg::*;

    logic [1:0]  cmd_reg;
    logic [23:0] vx_reg, vy_reg;
    logic        last_reg;
    logic [15:0] addr_reg;
    logic [23:0] fx_reg, fy_reg, px_reg, py_reg;
    logic        have_first_reg;
    logic [PIX_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [PIX_W-1:0] adx_reg, ady_reg, step_reg, cnt_reg;
    logic        negx_reg, negy_reg;
    logic [PIX_W+QUO_W-1:0] remx_reg, remy_reg; // shifting dividends
    logic [PIX_W:0]    partx_reg, party_reg;
    logic [QUO_W-1:0]  qx_reg, qy_reg;
    logic [$clog2(PIX_W+QUO_W+1)-1:0] dcnt_reg;
    logic [ACC_W-1:0]  ax_reg, ay_reg;
    logic        drop_reg;
    logic [GRID_AW-1:0] clr_reg;
    logic [7:0]  rd_reg;
    logic        rd_bad_reg;

    // scaling: one multiplier per coordinate, shared by both endpoints
    logic [23:0] sx_src, sy_src;
    logic [39:0] mx, my;
    logic [PIX_W-1:0] pxs, pys;
    always_comb
    begin
        if (ctl.scale_a)
        begin
            sx_src = px_reg;
            sy_src = py_reg;
        end
        else if (ctl.sel_close)
        begin
            sx_src = fx_reg;
            sy_src = fy_reg;
        end
        else
        begin
            sx_src = vx_reg;
            sy_src = vy_reg;
        end
        mx = 40'(sx_src) * 40'(scale);
        my = 40'(sy_src) * 40'(scale);
    end
    assign pxs = PIX_W'((41'(mx) + 41'h8000) >> 16);
    assign pys = PIX_W'((41'(my) + 41'h8000) >> 16);

    // restoring division trial subtract
    logic [PIX_W:0] tx, ty;
    assign tx = {partx_reg[PIX_W-1:0], remx_reg[PIX_W+QUO_W-1]};
    assign ty = {party_reg[PIX_W-1:0], remy_reg[PIX_W+QUO_W-1]};

    // pixel clamp and address
    logic [15:0] ecols, erows;
    logic [PIX_W-1:0] rxp, ryp;
    logic [15:0] cx, cy;
    logic [32:0] paddr;
    assign ecols = (cols == 16'd0) ? 16'd1 : cols;
    assign erows = (rows == 16'd0) ? 16'd1 : rows;
    assign rxp = PIX_W'((ax_reg + ACC_W'(1 << (DDA_FRAC_BITS-1))) >> DDA_FRAC_BITS);
    assign ryp = PIX_W'((ay_reg + ACC_W'(1 << (DDA_FRAC_BITS-1))) >> DDA_FRAC_BITS);
    assign cx = (rxp >= PIX_W'(ecols)) ? ecols - 16'd1 : rxp[15:0];
    assign cy = (ryp >= PIX_W'(erows)) ? erows - 16'd1 : ryp[15:0];
    assign paddr = 33'(cx) + 33'(32'(ecols) * 32'(cy));

    // grid memory
    logic            ram_we;
    logic [GRID_AW-1:0] ram_addr;
    logic [7:0]      ram_wdata, ram_rdata;
    logic            plot_ok;
    assign plot_ok = paddr < 33'(GRID_WORDS);
    always_comb
    begin
        ram_we = 1'b0;
        ram_addr = GRID_AW'(addr_reg);
        ram_wdata = mark;
        if (ctl.clr_step)
        begin
            ram_we = 1'b1;
            ram_addr = clr_reg;
            ram_wdata = 8'hFF;
        end
        else if (ctl.plot)
        begin
            ram_we = plot_ok;
            ram_addr = paddr[GRID_AW-1:0];
        end
    end

    polr_ram #(.WIDTH(8), .DEPTH(GRID_WORDS)) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // history, control registers and clear sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg <= '0;
            fy_reg <= '0;
            px_reg <= '0;
            py_reg <= '0;
            have_first_reg <= 1'b0;
            cmd_reg <= '0;
            last_reg <= 1'b0;
            clr_reg <= '0;
        end
        else
        begin
            if (ctl.load_in)
            begin
                cmd_reg <= in_cmd;
                last_reg <= in_last;
            end
            if (ctl.commit)
            begin
                if (!have_first_reg)
                begin
                    fx_reg <= vx_reg;
                    fy_reg <= vy_reg;
                end
                px_reg <= vx_reg;
                py_reg <= vy_reg;
                have_first_reg <= !last_reg;
            end
            if (ctl.clr_start)
            begin
                clr_reg <= '0;
            end
            if (ctl.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // payload and arithmetic registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            vx_reg <= in_x;
            vy_reg <= in_y;
            addr_reg <= in_addr;
            drop_reg <= 1'b0;
        end
        if (ctl.scale_a)
        begin
            x1_reg <= pxs;
            y1_reg <= pys;
        end
        if (ctl.scale_b)
        begin
            x2_reg <= pxs;
            y2_reg <= pys;
        end
        if (ctl.seg_setup)
        begin
            negx_reg <= x2_reg < x1_reg;
            negy_reg <= y2_reg < y1_reg;
            adx_reg <= (x2_reg >= x1_reg) ? x2_reg - x1_reg : x1_reg - x2_reg;
            ady_reg <= (y2_reg >= y1_reg) ? y2_reg - y1_reg : y1_reg - y2_reg;
        end
        if (ctl.div_start)
        begin
            step_reg <= (adx_reg >= ady_reg) ? adx_reg : ady_reg;
            remx_reg <= {adx_reg, QUO_W'(0)} >> 1;
            remy_reg <= {ady_reg, QUO_W'(0)} >> 1;
            partx_reg <= '0;
            party_reg <= '0;
            dcnt_reg <= '0;
        end
        if (ctl.div_step)
        begin
            // one quotient bit per cycle for each axis
            remx_reg <= {remx_reg[PIX_W+QUO_W-2:0], 1'b0};
            remy_reg <= {remy_reg[PIX_W+QUO_W-2:0], 1'b0};
            if (tx >= {1'b0, step_reg})
            begin
                partx_reg <= tx - {1'b0, step_reg};
                qx_reg <= {qx_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                partx_reg <= tx;
                qx_reg <= {qx_reg[QUO_W-2:0], 1'b0};
            end
            if (ty >= {1'b0, step_reg})
            begin
                party_reg <= ty - {1'b0, step_reg};
                qy_reg <= {qy_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                party_reg <= ty;
                qy_reg <= {qy_reg[QUO_W-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (ctl.dda_init)
        begin
            ax_reg <= ACC_W'(x1_reg) << DDA_FRAC_BITS;
            ay_reg <= ACC_W'(y1_reg) << DDA_FRAC_BITS;
            cnt_reg <= '0;
        end
        if (ctl.plot)
        begin
            drop_reg <= drop_reg | !plot_ok;
            ax_reg <= negx_reg ? ax_reg - ACC_W'(qx_reg) : ax_reg + ACC_W'(qx_reg);
            ay_reg <= negy_reg ? ay_reg - ACC_W'(qy_reg) : ay_reg + ACC_W'(qy_reg);
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (ctl.rd_take)
        begin
            rd_reg <= ram_rdata;
        end
        if (ctl.rd_issue)
        begin
            rd_bad_reg <= 32'(addr_reg) >= 32'(GRID_WORDS);
        end
    end

    // result formation
    always_comb
    begin
        res_data = 8'd0;
        res_status = ST_OK;
        unique case (cmd_reg)
            CMD_VERTEX: res_status = drop_reg ? ST_DROPPED : ST_OK;
            CMD_READ:
            begin
                if (rd_bad_reg)
                begin
                    res_status = ST_RANGE;
                end
                else
                begin
                    res_data = rd_reg;
                end
            end
            default: res_status = ST_OK;
        endcase
    end

    assign st.cmd = cmd_reg;
    assign st.have_first = have_first_reg;
    assign st.is_last = last_reg;
    assign st.need_close = (vx_reg != fx_reg) || (vy_reg != fy_reg);
    assign st.seg_zero = (adx_reg == '0) && (ady_reg == '0);
    assign st.div_done = 32'(dcnt_reg) == 32'(PIX_W + QUO_W);
    assign st.plot_done = (cnt_reg + 1'b1) == step_reg;
    assign st.clr_done = clr_reg == {GRID_AW{1'b1}};
endmodule
`default_nettype wire

FILE: design/polr_ctrl.sv
// Controller: sequences each item through the datapath
`default_nettype none
module polr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_fire,
    output logic                      in_ready,
    output logic                      res_load,
    input  wire logic                 res_free,
    input  wire polr_pkg::polr_stat_t st,
    output polr_pkg::polr_cmd_t       ctl
);
    import polr_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DEC    = 14'b00000000000010,
        S_SCA    = 14'b00000000000100,
        S_SCB    = 14'b00000000001000,
        S_SETUP  = 14'b00000000010000,
        S_DSTART = 14'b00000000100000,
        S_DIV    = 14'b00000001000000,
        S_INIT   = 14'b00000010000000,
        S_PLOT   = 14'b00000100000000,
        S_CLEAR  = 14'b00001000000000,
        S_READ   = 14'b00010000000000,
        S_RTAKE  = 14'b00100000000000,
        S_DONE   = 14'b01000000000000,
        S_BOOT   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   close_reg, close_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
            close_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            close_reg <= close_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        close_next = close_reg;
        ctl = '0;
        ctl.sel_close = close_reg;
        in_ready = 1'b0;
        res_load = 1'b0;
        unique case (state_reg)
            S_BOOT:
            begin
                // fill the grid with 255 after reset, no result
                ctl.clr_step = 1'b1;
                if (st.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load_in = in_fire;
                close_next = 1'b0;
                if (in_fire)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (st.cmd)
                    CMD_CLEAR:
                    begin
                        ctl.clr_start = 1'b1;
                        state_next = S_CLEAR;
                    end
                    CMD_VERTEX:
                    begin
                        if (st.have_first)
                        begin
                            state_next = S_SCA;
                        end
                        else if (st.is_last || !st.need_close)
                        begin
                            ctl.commit = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_DONE;
                            ctl.commit = 1'b1;
                        end
                    end
                    CMD_READ:
                    begin
                        state_next = S_READ;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_SCA:
            begin
                // close segment starts at the new vertex, held in prev after commit
                ctl.scale_a = 1'b1;
                state_next = S_SCB;
            end
            S_SCB:
            begin
                ctl.scale_b = 1'b1;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                ctl.seg_setup = 1'b1;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                ctl.div_start = 1'b1;
                state_next = st.seg_zero ? S_INIT : S_DIV;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (st.div_done)
                begin
                    ctl.div_step = 1'b0;
                    ctl.dda_init = 1'b1;
                    state_next = S_PLOT;
                end
            end
            S_INIT:
            begin
                // zero-length segment plots nothing
                if (!close_reg)
                begin
                    ctl.commit = 1'b1;
                end
                if (!close_reg && st.is_last && st.need_close)
                begin
                    close_next = 1'b1;
                    state_next = S_SCA;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PLOT:
            begin
                ctl.plot = 1'b1;
                if (st.plot_done)
                begin
                    state_next = S_INIT;
                end
            end
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (st.clr_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                ctl.rd_issue = 1'b1;
                state_next = S_RTAKE;
            end
            S_RTAKE:
            begin
                ctl.rd_take = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    res_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: design/polygon_outline_rasterizer.sv
// Top level of the polygon outline rasterizer
//  channel  dir  handshake             payload
//  s_axis   in   s_axis_tvalid/tready  tdata: cmd,x,y,last,addr
//  m_axis   out  m_axis_tvalid/tready  tdata: read_data,status
//  apb      in   psel/penable/pwrite   registers at 4*i
// Clear: one grid byte per cycle, until the whole grid holds 255.
// Vertex: per segment, setup and a division of 42 quotient bits, one per cycle,
// then the pixels are plotted in turn; a last vertex draws up to two segments.
// Read: the range is checked and the registered read data taken. After reset a
// clearing pass fills the grid with 255; input is held off until it ends.
// The result register holds one item; a stalled output holds the next result.
`default_nettype none
`include "assert_macros.svh"
module polygon_outline_rasterizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: cmd[1:0], vertex_x[25:2], vertex_y[49:26], last_vertex[50],
    // read_address[66:51]
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: read_data[7:0], status[9:8]
    output logic [15:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import polr_pkg::*;

    logic [15:0] cols_reg, rows_reg, scale_reg;
    logic [7:0]  mark_reg;
    logic        wr;
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 16'd256;
            rows_reg <= 16'd256;
            scale_reg <= 16'd256;
            mark_reg <= 8'd51;
        end
        else if (wr && paddr[1:0] == 2'd0)
        begin
            unique case (paddr[3:2])
                REG_COLS:  cols_reg <= pwdata[15:0];
                REG_ROWS:  rows_reg <= pwdata[15:0];
                REG_SCALE: scale_reg <= pwdata[15:0];
                REG_MARK:  mark_reg <= pwdata[7:0];
                default:   mark_reg <= mark_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_COLS:  prdata = {16'd0, cols_reg};
            REG_ROWS:  prdata = {16'd0, rows_reg};
            REG_SCALE: prdata = {16'd0, scale_reg};
            REG_MARK:  prdata = {24'd0, mark_reg};
            default:   prdata = 32'd0;
        endcase
    end

    polr_cmd_t  ctl;
    polr_stat_t st;
    logic       in_fire, res_load;
    logic [7:0] res_data;
    logic [1:0] res_status;
    logic       ovalid_reg;
    logic [15:0] odata_reg;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    polr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_ready (s_axis_tready),
        .res_load (res_load),
        .res_free (!ovalid_reg || m_axis_tready),
        .st       (st),
        .ctl      (ctl)
    );

    polr_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .st         (st),
        .in_cmd     (s_axis_tdata[1:0]),
        .in_x       (s_axis_tdata[25:2]),
        .in_y       (s_axis_tdata[49:26]),
        .in_last    (s_axis_tdata[50]),
        .in_addr    (s_axis_tdata[66:51]),
        .cols       (cols_reg),
        .rows       (rows_reg),
        .scale      (scale_reg),
        .mark       (mark_reg),
        .res_data   (res_data),
        .res_status (res_status)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            odata_reg <= {6'd0, res_status, res_data};
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = odata_reg;

    `ASSERT_IMPL(a_no_overwrite, clk, rst_n, res_load, (!ovalid_reg || m_axis_tready),
        "result overwritten")
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !s_axis_tready,
        "accepted while busy")
    `ASSERT_IMPL(a_read_zero, clk, rst_n, res_load && (res_status == ST_RANGE), res_data == 8'd0,
        "bad read with data")
endmodule
`default_nettype wire

FILE: tb/polr_outline_checker.sv
// Checker for the polygon outline rasterizer: tracks registers, predicts every result, compares
module polr_outline_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               mismatches,
    output int               outstanding,
    output int               results_seen,
    output int               drops_seen
);
    import polr_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
    } grid_result_t;

    // Shadow of the grid memory and polygon history
    logic [7:0]   grid_shadow [GRID_WORDS];
    logic [23:0]  first_x, first_y, prev_x, prev_y;
    logic         poly_open;
    logic [15:0]  cols_r, rows_r, scale_r;
    logic [7:0]   mark_r;
    grid_result_t expected_results [$];

    // Map units to pixels, product rounded half up
    function automatic longint unsigned to_pix(logic [23:0] v);
        return ((longint'(v) * longint'(scale_r)) + 64'd32768) >> 16;
    endfunction

    // Clamp into the grid and mark; returns 1 when the address is beyond capacity
    function automatic bit mark_pixel(longint unsigned px, longint unsigned py);
        longint unsigned cols, rows, addr;
        cols = (cols_r == 0) ? 1 : cols_r;
        rows = (rows_r == 0) ? 1 : rows_r;
        if (px >= cols) px = cols - 1;
        if (py >= rows) py = rows - 1;
        addr = px + cols * py;
        if (addr >= GRID_WORDS) return 1'b1;
        grid_shadow[addr[GRID_AW-1:0]] = mark_r;
        return 1'b0;
    endfunction

    // DDA from a to b, end pixel left out
    function automatic bit draw_line(logic [23:0] xa, logic [23:0] ya,
                                     logic [23:0] xb, logic [23:0] yb);
        longint unsigned x1, y1, x2, y2, adx, ady, steps, incx, incy, ax, ay, half;
        bit dropped;
        x1 = to_pix(xa);
        y1 = to_pix(ya);
        x2 = to_pix(xb);
        y2 = to_pix(yb);
        adx = (x2 >= x1) ? x2 - x1 : x1 - x2;
        ady = (y2 >= y1) ? y2 - y1 : y1 - y2;
        steps = (adx >= ady) ? adx : ady;
        dropped = 1'b0;
        if (steps == 0) return 1'b0;
        half = 64'd1 << (DDA_FRAC_BITS - 1);
        incx = (adx << DDA_FRAC_BITS) / steps;
        incy = (ady << DDA_FRAC_BITS) / steps;
        ax = x1 << DDA_FRAC_BITS;
        ay = y1 << DDA_FRAC_BITS;
        for (longint unsigned i = 0; i < steps; i++)
        begin
            dropped |= mark_pixel((ax + half) >> DDA_FRAC_BITS, (ay + half) >> DDA_FRAC_BITS);
            if (x2 >= x1) ax += incx; else ax -= incx;
            if (y2 >= y1) ay += incy; else ay -= incy;
        end
        return dropped;
    endfunction

    // Apply one accepted item to the shadow state and give its result
    function automatic grid_result_t rasterize_item(logic [71:0] item);
        logic [1:0]   op;
        logic [23:0]  vx, vy;
        logic         last;
        logic [15:0]  addr;
        grid_result_t res;
        bit           dropped;
        op = item[1:0];
        vx = item[25:2];
        vy = item[49:26];
        last = item[50];
        addr = item[66:51];
        res = '0;
        dropped = 1'b0;
        if (op == CMD_CLEAR)
        begin
            foreach (grid_shadow[i]) grid_shadow[i] = 8'hFF;
        end
        else if (op == CMD_VERTEX)
        begin
            if (!poly_open)
            begin
                first_x = vx;
                first_y = vy;
                poly_open = 1'b1;
            end
            else
                dropped |= draw_line(prev_x, prev_y, vx, vy);
            prev_x = vx;
            prev_y = vy;
            if (last)
            begin
                if (vx != first_x || vy != first_y)
                    dropped |= draw_line(vx, vy, first_x, first_y);
                poly_open = 1'b0;
            end
            res.status = dropped ? ST_DROPPED : ST_OK;
        end
        else if (op == CMD_READ)
        begin
            if (addr < GRID_WORDS) res.data = grid_shadow[addr];
            else res.status = ST_RANGE;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grid_result_t want;
        if (!rst_n)
        begin
            // the grid comes out of reset filled with 255
            foreach (grid_shadow[i]) grid_shadow[i] = 8'hFF;
            first_x = '0;
            first_y = '0;
            prev_x = '0;
            prev_y = '0;
            poly_open = 1'b0;
            cols_r = 16'd256;
            rows_r = 16'd256;
            scale_r = 16'd256;
            mark_r = 8'd51;
            expected_results.delete();
            mismatches = 0;
            outstanding = 0;
            results_seen = 0;
            drops_seen = 0;
        end
        else
        begin
            // Register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_COLS:  cols_r = pwdata[15:0];
                    REG_ROWS:  rows_r = pwdata[15:0];
                    REG_SCALE: scale_r = pwdata[15:0];
                    REG_MARK:  mark_r = pwdata[7:0];
                endcase
            end
            // Accepted input item
            if (s_tvalid && s_tready)
                expected_results.push_back(rasterize_item(s_tdata));
            // Accepted result item
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected", m_tdata, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (want.status == ST_DROPPED) drops_seen++;
                    if (m_tdata[7:0] != want.data)
                        report_mismatch("read_data", m_tdata[7:0], want.data);
                    if (m_tdata[9:8] != want.status)
                        report_mismatch("status", m_tdata[9:8], want.status);
                end
            end
            outstanding = expected_results.size();
        end
    end
endmodule

FILE: tb/polygon_outline_rasterizer_tb.sv
// Top of the rasterizer testbench: clock, reset, stimulus and verdict
module polygon_outline_rasterizer_tb;
    import polr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // tdata: cmd[1:0], vertex_x[25:2], vertex_y[49:26], last_vertex[50], read_address[66:51]
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // tdata: read_data[7:0], status[9:8]
    logic [15:0] m_axis_tdata;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;

    int          mismatches, outstanding, results_seen, drops_seen;
    int          items_sent;
    int          settings_run;
    logic        hold_off_go;
    logic [15:0] cur_cols, cur_rows, cur_scale;

    polygon_outline_rasterizer dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    polr_outline_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tdata(s_axis_tdata),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .mismatches(mismatches), .outstanding(outstanding),
        .results_seen(results_seen), .drops_seen(drops_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit
    initial
    begin
        #100000000;
        $display("polygon_outline_rasterizer: mismatch");
        $finish;
    end

    // Result side: random stalls plus one long hold-off to back up the input
    initial
    begin
        int hold;
        bit held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_go && !held)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                hold = 0;
                while (hold < 3000)
                begin
                    @(posedge clk);
                    hold++;
                end
            end
            else if ($urandom_range(0, 99) < 70)
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
                else repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end
    end

    // Offer one item after a random gap; valid stays high on return
    task automatic send_item(logic [1:0] op, logic [23:0] vx, logic [23:0] vy,
                             logic last, logic [15:0] addr);
        int r, gap;
        r = $urandom_range(0, 99);
        gap = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, addr, last, vy, vx, op};
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Item with every field random, command given
    task automatic send_random(logic [1:0] op);
        send_item(op, 24'($urandom), 24'($urandom), 1'($urandom), 16'($urandom));
    endtask

    // Let the block drain, then write one register
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (20) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_COLS) cur_cols = value[15:0];
        if (idx == REG_ROWS) cur_rows = value[15:0];
        if (idx == REG_SCALE) cur_scale = value[15:0];
    endtask

    task automatic apply_setting(logic [15:0] c, logic [15:0] rw, logic [15:0] sc,
                                 logic [7:0] mk);
        write_reg(REG_COLS, 32'(c));
        write_reg(REG_ROWS, 32'(rw));
        write_reg(REG_SCALE, 32'(sc));
        write_reg(REG_MARK, 32'(mk));
        settings_run++;
    endtask

    // Coordinate near a base, offset given in pixels, kept inside 24 bits
    function automatic logic [23:0] near_coord(int base, int pix_off);
        longint v;
        int unit;
        unit = 65536 / ((cur_scale == 0) ? 1 : int'(cur_scale));
        v = longint'(base) + longint'(pix_off) * unit;
        if (v < 0) v = 0;
        if (v > 24'hFFFFFF) v = 24'hFFFFFF;
        return v[23:0];
    endfunction

    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 16'($urandom_range(1, 300));
        if (r < 75) return 16'($urandom_range(1, 65535));
        return (r < 88) ? 16'd1 : 16'd65535;
    endfunction

    // Random reads, mostly inside the used part of the grid
    task automatic send_read();
        int span;
        span = int'(cur_cols) * int'(cur_rows);
        if (span > 65535 || span == 0) span = 65535;
        if ($urandom_range(0, 3) == 0) send_random(CMD_READ);
        else send_item(CMD_READ, 24'($urandom), 24'($urandom), 1'($urandom),
                       16'($urandom_range(0, span)));
    endtask

    // One well-formed polygon with small segments, reads mixed in now and then
    task automatic send_polygon();
        int nv, bx, by;
        nv = $urandom_range(1, 6);
        if ($urandom_range(0, 1) == 0)
        begin
            bx = int'(near_coord(0, $urandom_range(0, 400)));
            by = int'(near_coord(0, $urandom_range(0, 400)));
        end
        else
        begin
            bx = $urandom_range(0, 24'hFFFFFF);
            by = $urandom_range(0, 24'hFFFFFF);
        end
        for (int k = 0; k < nv; k++)
        begin
            if ($urandom_range(0, 9) == 0) send_read();
            send_item(CMD_VERTEX, near_coord(bx, int'($urandom_range(0, 80)) - 40),
                      near_coord(by, int'($urandom_range(0, 80)) - 40), k == nv - 1,
                      16'($urandom));
        end
    endtask

    initial
    begin
        int r;
        int phase_items;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        hold_off_go = 1'b0;
        items_sent = 0;
        settings_run = 1;
        cur_cols = 16'd256;
        cur_rows = 16'd256;
        cur_scale = 16'd256;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: read a byte straight after reset, clear, then a small triangle
        send_item(CMD_READ, 24'd0, 24'd0, 1'b0, 16'd777);
        send_item(CMD_CLEAR, 24'd0, 24'd0, 1'b0, 16'd0);
        send_item(CMD_VERTEX, 24'd2560, 24'd2560, 1'b0, 16'd0);
        send_item(CMD_VERTEX, 24'd10240, 24'd5120, 1'b0, 16'd0);
        send_item(CMD_VERTEX, 24'd6400, 24'd12800, 1'b1, 16'd0);
        send_item(CMD_READ, 24'd0, 24'd0, 1'b0, 16'd2570);
        send_item(CMD_READ, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 16'd10 + 16'd256 * 16'd20);
        // single vertex polygon, then a zero-length segment
        send_item(CMD_VERTEX, 24'd4000, 24'd4000, 1'b1, 16'd0);
        send_item(CMD_VERTEX, 24'd4000, 24'd4000, 1'b0, 16'd0);
        send_item(CMD_VERTEX, 24'd4000, 24'd4000, 1'b1, 16'd0);
        // polygon left open across a clear
        send_item(CMD_VERTEX, 24'd1000, 24'd300, 1'b0, 16'd0);
        send_item(CMD_CLEAR, 24'd0, 24'd0, 1'b0, 16'd0);
        send_item(CMD_VERTEX, 24'd3000, 24'd9000, 1'b1, 16'd0);
        send_item(CMD_READ, 24'd0, 24'd0, 1'b0, 16'd3 + 16'd256 * 16'd1);
        // top corner, pixels clamp to the last row and column
        send_item(CMD_VERTEX, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 16'd0);
        send_item(CMD_VERTEX, 24'hFFFF00, 24'hFFF000, 1'b1, 16'd0);
        send_item(CMD_READ, 24'd0, 24'd0, 1'b0, 16'hFFFF);
        send_item(CMD_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 16'hFFFF);
        send_item(CMD_READ, 24'd0, 24'd0, 1'b0, 16'd0);
        // zero grid size acts as one; scale at its top, mark at zero
        apply_setting(16'd0, 16'd0, 16'hFFFF, 8'd0);
        send_item(CMD_VERTEX, 24'd5, 24'd9, 1'b0, 16'd0);
        send_item(CMD_VERTEX, 24'd40, 24'd3, 1'b1, 16'd0);
        send_item(CMD_READ, 24'd0, 24'd0, 1'b0, 16'd0);
        // largest grid drops writes past capacity; zero scale collapses to the origin
        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_item(CMD_VERTEX, 24'd10, 24'd1, 1'b0, 16'd0);
        send_item(CMD_VERTEX, 24'd12, 24'd3, 1'b1, 16'd0);
        apply_setting(16'hFFFF, 16'hFFFF, 16'd0, 8'hAA);
        send_item(CMD_VERTEX, 24'hFFFFFF, 24'd0, 1'b0, 16'd0);
        send_item(CMD_VERTEX, 24'd0, 24'hFFFFFF, 1'b1, 16'd0);
        send_item(CMD_READ, 24'd0, 24'd0, 1'b0, 16'd0);

        // Random phases, each under a fresh register setting
        for (int ph = 0; ph < 5; ph++)
        begin
            r = $urandom_range(0, 4);
            apply_setting(pick_size(), pick_size(),
                          (r == 0) ? 16'd0 : (r == 1) ? 16'd1 : (r == 2) ? 16'd256 :
                          (r == 3) ? 16'hFFFF : 16'($urandom_range(1, 65535)),
                          8'($urandom_range(0, 255)));
            if (ph == 2 || ph == 4) send_random(CMD_CLEAR);
            if (ph == 1) hold_off_go = 1'b1;
            phase_items = items_sent;
            while (items_sent - phase_items < 200)
            begin
                r = $urandom_range(0, 99);
                if (r < 72) send_polygon();
                else if (r < 96) send_read();
                else send_random(CMD_UNUSED);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (100) @(posedge clk);
        $display("Sent %0d items over %0d register settings, checked %0d results", items_sent,
                 settings_run, results_seen);
        $display("Vertex results with dropped writes: %0d", drops_seen);
        if (mismatches == 0)
            $display("polygon_outline_rasterizer: match");
        else
            $display("polygon_outline_rasterizer: mismatch");
        $finish;
    end
endmodule
